[sv/vlc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlc_pkg
// shared constants for the vector length clamp
// ----------------------------------------------------------------------------
package vlc_pkg;
  // max length register: unsigned, 31 bits
  localparam int unsigned LIM_W = 31;
  localparam logic [LIM_W-1:0] LIM_RESET = 31'd65536;
  // scaled magnitude never exceeds the max length
  localparam int unsigned QUO_W = LIM_W;
endpackage

[sv/vector3_length_clamp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_length_clamp_core
// caps the euclidean length of a signed fixed-point 3-vector
// ----------------------------------------------------------------------------
// usage
//   input: pulse start with in_x/in_y/in_z; a transfer happens when start is
//   high and busy is low. busy is always low, so a vector can enter on
//   every clock.
//   output: done is high for one cycle with out_x/out_y/out_z and
//   was_clamped; the receiver cannot stall, results are never held back.
//   throughput: one vector per cycle.
//   path: after the start transfer, a vector passes the square root
//   pipeline (one root bit per stage) and then the divide pipeline (31
//   quotient bits, one a stage) before done goes high.
//   config: cfg_write loads max_length from cfg_wdata; write it only while
//   no vector is in flight.
//   reset: rst (sync) empties the pipeline and sets max_length to 1.0.
//   structure: three component lanes in parallel share one square root;
//   a merge stage picks scaled or pass-through values per the clamp flag.
// ----------------------------------------------------------------------------
module vector3_length_clamp_core #(
  parameter int COMPONENT_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COMPONENT_WIDTH-1:0] in_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_z,
  input  logic                             cfg_write,
  input  logic [vlc_pkg::LIM_W-1:0]        cfg_wdata,
  output logic                             done,
  output logic signed [COMPONENT_WIDTH-1:0] out_x,
  output logic signed [COMPONENT_WIDTH-1:0] out_y,
  output logic signed [COMPONENT_WIDTH-1:0] out_z,
  output logic                             was_clamped
);
  localparam int CW    = COMPONENT_WIDTH;
  localparam int LW    = vlc_pkg::LIM_W;
  localparam int SW    = 2 * CW;
  localparam int CMP_W = (SW > 2 * LW) ? SW : 2 * LW;
  // valid chain covers input register through lane outputs
  localparam int VLEN  = CW + 36;

  logic [LW-1:0] max_length;

  // fully pipelined, never refuses a transfer
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= vlc_pkg::LIM_RESET;
    end else if (cfg_write) begin
      max_length <= cfg_wdata;
    end
  end

  // input register
  logic [CW-1:0] x_s, y_s, z_s;
  logic [LW-1:0] lim_s;
  always_ff @(posedge clk) begin
    x_s   <= in_x;
    y_s   <= in_y;
    z_s   <= in_z;
    lim_s <= max_length;
  end

  // valid tracking
  logic [VLEN-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[VLEN-2:0], start & ~busy};
      done <= vld[VLEN-1];
    end
  end

  // max squared, lined up with the sum of squares
  logic [2*LW-1:0] limsq_a, limsq_b, limsq_c;
  always_ff @(posedge clk) begin
    limsq_a <= lim_s * lim_s;
    limsq_b <= limsq_a;
    limsq_c <= limsq_b;
  end

  // lanes
  logic [SW-1:0] sq_x, sq_y, sq_z;
  logic [CW-1:0] sc_x, sc_y, sc_z;
  logic [CW-1:0] rw_x, rw_y, rw_z;
  logic [CW-1:0] root;

  vlc_lane #(.CW(CW)) u_lane_x (
    .clk(clk), .raw(x_s), .lim(lim_s), .root(root),
    .sq(sq_x), .scaled(sc_x), .raw_out(rw_x)
  );
  vlc_lane #(.CW(CW)) u_lane_y (
    .clk(clk), .raw(y_s), .lim(lim_s), .root(root),
    .sq(sq_y), .scaled(sc_y), .raw_out(rw_y)
  );
  vlc_lane #(.CW(CW)) u_lane_z (
    .clk(clk), .raw(z_s), .lim(lim_s), .root(root),
    .sq(sq_z), .scaled(sc_z), .raw_out(rw_z)
  );

  // sum of squares: below 2^(2*CW) for any inputs
  logic [SW-1:0] sumsq;
  always_ff @(posedge clk) begin
    sumsq <= sq_x + sq_y + sq_z;
  end

  // exact compare against max squared
  logic clamp;
  always_ff @(posedge clk) begin
    clamp <= CMP_W'(sumsq) > CMP_W'(limsq_c);
  end

  vlc_sqrt #(.CW(CW)) u_sqrt (.clk(clk), .value(sumsq), .root(root));

  logic clamp_d;
  vlc_delay #(.W(1), .D(CW + 31)) u_flag_dly (.clk(clk), .din(clamp), .dout(clamp_d));

  // merge: scaled when clamped, otherwise the vector as it came in
  always_ff @(posedge clk) begin
    out_x       <= clamp_d ? sc_x : rw_x;
    out_y       <= clamp_d ? sc_y : rw_y;
    out_z       <= clamp_d ? sc_z : rw_z;
    was_clamped <= clamp_d;
  end
endmodule

[sv/vlc_delay.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlc_delay
// fixed-length register delay line
// ----------------------------------------------------------------------------
module vlc_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);
  logic [W-1:0] taps [D];

  always_ff @(posedge clk) begin
    taps[0] <= din;
    for (int i = 1; i < D; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[D-1];
endmodule

[sv/vlc_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlc_sqrt
// pipelined floor square root, one root bit per stage
// ----------------------------------------------------------------------------
module vlc_sqrt #(
  parameter int CW = 32
) (
  input  logic            clk,
  input  logic [2*CW-1:0] value,
  output logic [CW-1:0]   root
);
  localparam int SW = 2 * CW;

  logic [SW-1:0] rem_q  [1:CW];
  logic [SW-1:0] root_q [1:CW];

  for (genvar k = 0; k < CW; k++) begin : g_stage
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (CW - 1 - k));
    logic [SW-1:0] rem_in;
    logic [SW-1:0] root_in;
    logic [SW-1:0] trial;
    if (k == 0) begin : g_first
      assign rem_in  = value;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k];
      assign root_in = root_q[k];
    end
    assign trial = root_in + BIT;
    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        rem_q[k+1]  <= rem_in - trial;
        root_q[k+1] <= (root_in >> 1) + BIT;
      end else begin
        rem_q[k+1]  <= rem_in;
        root_q[k+1] <= root_in >> 1;
      end
    end
  end

  assign root = root_q[CW][CW-1:0];
endmodule

[sv/vlc_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlc_lane
// one vector component: square, scale product, divide by length, re-sign
// ----------------------------------------------------------------------------
module vlc_lane #(
  parameter int CW = 32
) (
  input  logic                      clk,
  input  logic [CW-1:0]             raw,
  input  logic [vlc_pkg::LIM_W-1:0] lim,
  input  logic [CW-1:0]             root,
  output logic [2*CW-1:0]           sq,
  output logic [CW-1:0]             scaled,
  output logic [CW-1:0]             raw_out
);
  localparam int LW = vlc_pkg::LIM_W;
  localparam int QW = vlc_pkg::QUO_W;
  localparam int PW = CW + LW;

  logic [CW-1:0] mag;
  logic [LW-1:0] lim_a;
  logic [PW-1:0] prod;
  logic [PW-1:0] prod_d;
  logic [CW-1:0] raw_d;

  always_ff @(posedge clk) begin
    mag   <= raw[CW-1] ? (~raw + CW'(1)) : raw;
    lim_a <= lim;
    sq    <= mag * mag;
    prod  <= PW'(mag) * PW'(lim_a);
  end

  // line the product up with the root
  vlc_delay #(.W(PW), .D(CW + 1)) u_prod_dly (.clk(clk), .din(prod), .dout(prod_d));
  vlc_delay #(.W(CW), .D(CW + 34)) u_raw_dly (.clk(clk), .din(raw), .dout(raw_d));

  // restoring division, one quotient bit per stage
  logic [CW-1:0] rem_q [1:QW];
  logic [LW-1:0] low_q [1:QW];
  logic [CW-1:0] div_q [1:QW];
  logic [QW-1:0] quo_q [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [CW-1:0] rem_in;
    logic [LW-1:0] low_in;
    logic [CW-1:0] div_in;
    logic [QW-1:0] quo_in;
    logic [CW:0]   trial;
    if (k == 0) begin : g_first
      assign rem_in = prod_d[PW-1:LW];
      assign low_in = prod_d[LW-1:0];
      assign div_in = root;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k];
      assign low_in = low_q[k];
      assign div_in = div_q[k];
      assign quo_in = quo_q[k];
    end
    assign trial = {rem_in, low_in[LW-1-k]};
    always_ff @(posedge clk) begin
      low_q[k+1] <= low_in;
      div_q[k+1] <= div_in;
      if (trial >= {1'b0, div_in}) begin
        rem_q[k+1] <= CW'(trial - {1'b0, div_in});
        quo_q[k+1] <= {quo_in[QW-2:0], 1'b1};
      end else begin
        rem_q[k+1] <= CW'(trial);
        quo_q[k+1] <= {quo_in[QW-2:0], 1'b0};
      end
    end
  end

  logic [CW-1:0] qc;
  assign qc = CW'(quo_q[QW]);

  always_ff @(posedge clk) begin
    scaled  <= raw_d[CW-1] ? (~qc + CW'(1)) : qc;
    raw_out <= raw_d;
  end
endmodule
